/* rtl/psgrfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_pkg
// Shared types, codes and helper functions of the register frame applier.
// ----------------------------------------------------------------------------
package psgrfa_pkg;

  localparam int CFG_DW   = 8;
  localparam int CFG_IW   = 1;
  localparam int PEND_W   = 14;

  localparam logic [CFG_IW-1:0] CFG_VOL_GAIN      = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_STREAM_ACTIVE = 1'd1;

  localparam logic [7:0] VOL_RESET   = 8'd128;
  localparam logic [7:0] VOL_MAX     = 8'd15;
  localparam int         VOL_ENV_BIT = 4;
  localparam logic [5:0] MIX_ALL     = 6'h3F;
  localparam logic [5:0] VOICE_MIX   = 6'h09;
  localparam int         OWN_NOISE   = 3;

  localparam logic [3:0] REG_NOISE   = 4'd6;
  localparam logic [3:0] REG_MIXER   = 4'd7;
  localparam logic [3:0] REG_VOL_LO  = 4'd8;
  localparam logic [3:0] REG_VOL_HI  = 4'd10;
  localparam logic [3:0] REG_TONE_HI = 4'd5;
  localparam logic [3:0] REG_LAST    = 4'd13;

  typedef enum logic [1:0] {
    MODE_STREAM  = 2'd0,
    MODE_RESTORE = 2'd1,
    MODE_SILENCE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_MIXER = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_MASK_HI = 2'd0,
    PH_MASK_LO = 2'd1,
    PH_VALUES  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ENT_SINGLE  = 2'd0,
    ENT_RESTORE = 2'd1,
    ENT_SILENCE = 2'd2
  } ent_op_t;

  // restore sequence slots
  localparam logic [2:0] SLOT_TONE_LO = 3'd0;
  localparam logic [2:0] SLOT_TONE_HI = 3'd1;
  localparam logic [2:0] SLOT_VOL     = 3'd2;
  localparam logic [2:0] SLOT_NOISE   = 3'd3;
  localparam logic [2:0] SLOT_MIXER   = 3'd4;

  typedef struct packed {
    logic [7:0] vol;
    logic [7:0] tone_hi;
    logic [7:0] tone_lo;
  } lane_t;

  typedef struct packed {
    ent_op_t    op;
    kind_t      kind;
    logic [3:0] reg_index;
    logic [7:0] write_value;
    logic [5:0] mixer_mask;
    logic       frame_end;
    logic [1:0] voice;
    logic [3:0] own;
    logic       active;
    lane_t      lane;
    logic [7:0] noise;
    logic [7:0] mixer;
    logic [2:0] start;
  } ent_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] reg_index;
    logic [7:0] write_value;
    logic [5:0] mixer_mask;
    logic       frame_end;
    logic       last;
  } res_t;

  function automatic logic [5:0] voice_bits(input logic [1:0] v);
    logic [5:0] b;
    b = 6'(VOICE_MIX << v);
    return b;
  endfunction

  function automatic logic [7:0] vol_scale(input logic [7:0] val, input logic [7:0] vol);
    logic [15:0] prod;
    logic [8:0]  s;
    prod = 16'(val) * 16'(vol);
    s    = prod[15:7];
    if (val[VOL_ENV_BIT]) begin
      return val;
    end else if (s > 9'(VOL_MAX)) begin
      return VOL_MAX;
    end
    return s[7:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/psgrfa_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_in_if
// Input channel: one stream byte or command per transfer.
// ----------------------------------------------------------------------------
interface psgrfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [1:0] voice;
  logic [3:0] owned_voices;

  modport source (output valid, mode, data_byte, voice, owned_voices, input ready);
  modport sink   (input valid, mode, data_byte, voice, owned_voices, output ready);
endinterface
`default_nettype wire

/* rtl/psgrfa_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_out_if
// Result channel: one register write, mixer update or marker per transfer.
// ----------------------------------------------------------------------------
interface psgrfa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] reg_index;
  logic [7:0] write_value;
  logic [5:0] mixer_mask;
  logic       frame_end;
  logic       last;

  modport source (output valid, kind, reg_index, write_value, mixer_mask, frame_end, last,
                  input ready);
  modport sink   (input valid, kind, reg_index, write_value, mixer_mask, frame_end, last,
                  output ready);
endinterface
`default_nettype wire

/* rtl/psgrfa_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_front
// Frame parser and register shadow; turns each input into one queue entry.
// ----------------------------------------------------------------------------
module psgrfa_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  psgrfa_in_if.sink                 in_ch,
  input  wire logic                 q_full,
  input  wire logic [7:0]           vol_gain,
  input  wire logic                 stream_active,
  output logic                      push,
  output psgrfa_pkg::ent_t          push_ent
);

  psgrfa_pkg::phase_t             phase_r, phase_nxt;
  logic [psgrfa_pkg::PEND_W-1:0]  pm_r, pm_nxt;
  psgrfa_pkg::lane_t              lane_r [3];
  psgrfa_pkg::lane_t              lane_nxt [3];
  logic [7:0]                     noise_r, noise_nxt;
  logic [7:0]                     mixer_r, mixer_nxt;

  logic [psgrfa_pkg::PEND_W-1:0]  pm_lo, pm_clr;
  logic [3:0]                     sel;
  logic                           owned;
  logic [5:0]                     keep;
  logic [2:0]                     unowned;
  logic [7:0]                     b;
  logic [3:0]                     own;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign own         = in_ch.owned_voices;
  assign unowned     = ~own[2:0];
  assign pm_lo       = pm_r | psgrfa_pkg::PEND_W'(b);
  assign pm_clr      = pm_r & (pm_r - psgrfa_pkg::PEND_W'(1));

  always_comb begin
    sel = psgrfa_pkg::REG_LAST;
    for (int i = psgrfa_pkg::PEND_W - 2; i >= 0; i--) begin
      if (pm_r[i]) sel = 4'(i);
    end
  end

  always_comb begin
    keep = '0;
    for (int v = 0; v < 3; v++) begin
      if (own[v]) keep = keep | psgrfa_pkg::voice_bits(2'(v));
    end
  end

  always_comb begin
    if (sel <= psgrfa_pkg::REG_TONE_HI) begin
      owned = own[sel[2:1]];
    end else if (sel >= psgrfa_pkg::REG_VOL_LO && sel <= psgrfa_pkg::REG_VOL_HI) begin
      owned = own[sel[1:0]];
    end else if (sel == psgrfa_pkg::REG_NOISE) begin
      owned = own[psgrfa_pkg::OWN_NOISE];
    end else begin
      owned = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pm_nxt    = pm_r;
    lane_nxt  = lane_r;
    noise_nxt = noise_r;
    mixer_nxt = mixer_r;

    push_ent             = '0;
    push_ent.op          = psgrfa_pkg::ENT_SINGLE;
    push_ent.kind        = psgrfa_pkg::KIND_NONE;
    push_ent.voice       = in_ch.voice;
    push_ent.own         = own;
    push_ent.active      = stream_active;
    push_ent.lane        = (in_ch.voice == 2'd3) ? '0 : lane_r[in_ch.voice];
    push_ent.noise       = noise_r;
    push_ent.mixer       = mixer_r;

    unique case (in_ch.mode)
      psgrfa_pkg::MODE_STREAM: begin
        if (phase_r == psgrfa_pkg::PH_MASK_LO) begin
          pm_nxt             = pm_lo;
          phase_nxt          = (pm_lo == '0) ? psgrfa_pkg::PH_MASK_HI : psgrfa_pkg::PH_VALUES;
          push_ent.frame_end = (pm_lo == '0);
        end else if (phase_r != psgrfa_pkg::PH_VALUES || pm_r == '0) begin
          pm_nxt    = {b[5:0], 8'h00};
          phase_nxt = psgrfa_pkg::PH_MASK_LO;
        end else begin
          pm_nxt             = pm_clr;
          push_ent.frame_end = (pm_clr == '0);
          if (pm_clr == '0) phase_nxt = psgrfa_pkg::PH_MASK_HI;

          if (sel <= psgrfa_pkg::REG_TONE_HI) begin
            if (sel[0]) lane_nxt[sel[2:1]].tone_hi = b;
            else        lane_nxt[sel[2:1]].tone_lo = b;
          end else if (sel >= psgrfa_pkg::REG_VOL_LO && sel <= psgrfa_pkg::REG_VOL_HI) begin
            lane_nxt[sel[1:0]].vol = b;
          end else if (sel == psgrfa_pkg::REG_NOISE) begin
            noise_nxt = b;
          end else if (sel == psgrfa_pkg::REG_MIXER) begin
            mixer_nxt = b;
          end

          if (owned) begin
            push_ent.kind = psgrfa_pkg::KIND_NONE;
          end else if (sel == psgrfa_pkg::REG_MIXER) begin
            push_ent.kind        = psgrfa_pkg::KIND_MIXER;
            push_ent.reg_index   = psgrfa_pkg::REG_MIXER;
            push_ent.write_value = {2'b00, b[5:0] & ~keep};
            push_ent.mixer_mask  = psgrfa_pkg::MIX_ALL & ~keep;
          end else begin
            push_ent.kind        = psgrfa_pkg::KIND_WRITE;
            push_ent.reg_index   = sel;
            push_ent.write_value =
              (sel >= psgrfa_pkg::REG_VOL_LO && sel <= psgrfa_pkg::REG_VOL_HI) ?
              psgrfa_pkg::vol_scale(b, vol_gain) : b;
          end
        end
      end
      psgrfa_pkg::MODE_RESTORE: begin
        if (in_ch.voice != 2'd3) begin
          push_ent.op    = psgrfa_pkg::ENT_RESTORE;
          push_ent.start = stream_active ? psgrfa_pkg::SLOT_TONE_LO : psgrfa_pkg::SLOT_VOL;
        end
      end
      psgrfa_pkg::MODE_SILENCE: begin
        if (unowned != '0) begin
          push_ent.op    = psgrfa_pkg::ENT_SILENCE;
          push_ent.start = unowned[0] ? 3'b000 : (unowned[1] ? 3'b010 : 3'b100);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= psgrfa_pkg::PH_MASK_HI;
      pm_r    <= '0;
      lane_r  <= '{default: '0};
      noise_r <= '0;
      mixer_r <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      pm_r    <= pm_nxt;
      lane_r  <= lane_nxt;
      noise_r <= noise_nxt;
      mixer_r <= mixer_nxt;
    end
  end

  a_values_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == psgrfa_pkg::PH_VALUES) |-> (pm_r != '0))
    else $error("value phase with empty pending mask");

endmodule
`default_nettype wire

/* rtl/psgrfa_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_queue
// Small FIFO of classified entries between parser and result sequencer.
// ----------------------------------------------------------------------------
module psgrfa_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire psgrfa_pkg::ent_t push_ent,
  input  wire logic             pop,
  output logic                  full,
  output logic                  q_valid,
  output psgrfa_pkg::ent_t      head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  psgrfa_pkg::ent_t mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

/* rtl/psgrfa_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psgrfa_back
// Result sequencer: expands queue entries into results, one per cycle while
// the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module psgrfa_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire psgrfa_pkg::ent_t head,
  input  wire logic [7:0]       vol_gain,
  output logic                  q_pop,
  psgrfa_out_if.source          out_ch
);

  logic              act_r;
  logic [2:0]        step_r;
  logic              out_valid_r;
  psgrfa_pkg::res_t  out_r;

  logic [2:0]        cur, step_nxt;
  logic              last_e, load;
  logic [5:0]        vb;
  logic [1:0]        sv;
  psgrfa_pkg::res_t  res;

  assign cur   = act_r ? step_r : head.start;
  assign sv    = cur[2:1];
  assign load  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = load && last_e;

  always_comb begin
    res      = '0;
    res.kind = psgrfa_pkg::KIND_NONE;
    last_e   = 1'b1;
    step_nxt = cur;
    vb       = '0;
    unique case (head.op)
      psgrfa_pkg::ENT_SINGLE: begin
        res.kind        = head.kind;
        res.reg_index   = head.reg_index;
        res.write_value = head.write_value;
        res.mixer_mask  = head.mixer_mask;
        res.frame_end   = head.frame_end;
      end
      psgrfa_pkg::ENT_RESTORE: begin
        vb = psgrfa_pkg::voice_bits(head.voice);
        case (cur)
          psgrfa_pkg::SLOT_TONE_LO: begin
            res.kind        = psgrfa_pkg::KIND_WRITE;
            res.reg_index   = {1'b0, head.voice, 1'b0};
            res.write_value = head.lane.tone_lo;
            last_e          = 1'b0;
            step_nxt        = psgrfa_pkg::SLOT_TONE_HI;
          end
          psgrfa_pkg::SLOT_TONE_HI: begin
            res.kind        = psgrfa_pkg::KIND_WRITE;
            res.reg_index   = {1'b0, head.voice, 1'b1};
            res.write_value = head.lane.tone_hi;
            last_e          = 1'b0;
            step_nxt        = psgrfa_pkg::SLOT_VOL;
          end
          psgrfa_pkg::SLOT_VOL: begin
            res.kind        = psgrfa_pkg::KIND_WRITE;
            res.reg_index   = {2'b10, head.voice};
            res.write_value = head.active ?
                              psgrfa_pkg::vol_scale(head.lane.vol, vol_gain) : '0;
            last_e          = 1'b0;
            step_nxt        = (head.own[psgrfa_pkg::OWN_NOISE] || !head.active) ?
                              psgrfa_pkg::SLOT_MIXER : psgrfa_pkg::SLOT_NOISE;
          end
          psgrfa_pkg::SLOT_NOISE: begin
            res.kind        = psgrfa_pkg::KIND_WRITE;
            res.reg_index   = psgrfa_pkg::REG_NOISE;
            res.write_value = head.noise;
            last_e          = 1'b0;
            step_nxt        = psgrfa_pkg::SLOT_MIXER;
          end
          default: begin
            res.kind        = psgrfa_pkg::KIND_MIXER;
            res.reg_index   = psgrfa_pkg::REG_MIXER;
            res.write_value = {2'b00, head.active ? (head.mixer[5:0] & vb) : vb};
            res.mixer_mask  = vb;
          end
        endcase
      end
      psgrfa_pkg::ENT_SILENCE: begin
        vb = psgrfa_pkg::voice_bits(sv);
        if (!cur[0]) begin
          res.kind      = psgrfa_pkg::KIND_WRITE;
          res.reg_index = {2'b10, sv};
          last_e        = 1'b0;
          step_nxt      = {sv, 1'b1};
        end else begin
          res.kind        = psgrfa_pkg::KIND_MIXER;
          res.reg_index   = psgrfa_pkg::REG_MIXER;
          res.write_value = {2'b00, vb};
          res.mixer_mask  = vb;
          // move on to the next voice that effects leave free
          if (sv == 2'd0 && !head.own[1]) begin
            last_e   = 1'b0;
            step_nxt = 3'b010;
          end else if (sv <= 2'd1 && !head.own[2]) begin
            last_e   = 1'b0;
            step_nxt = 3'b100;
          end
        end
      end
      default: begin
      end
    endcase
    res.last = last_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        act_r       <= !last_e;
        step_r      <= step_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.reg_index   = out_r.reg_index;
  assign out_ch.write_value = out_r.write_value;
  assign out_ch.mixer_mask  = out_r.mixer_mask;
  assign out_ch.frame_end   = out_r.frame_end;
  assign out_ch.last        = out_r.last;

  a_active_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> q_valid)
    else $error("sequencer mid-entry with empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_ch.valid && out_ch.last))
    else $error("entry retired without a last result");

endmodule
`default_nettype wire

/* rtl/psg_register_frame_applier.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psg_register_frame_applier
// Sound-chip register frame applier: parses change-mask frames, applies
// effect ownership and volume scaling, and emits register writes.
// ----------------------------------------------------------------------------
// Takes one input transfer per cycle while the internal queue has room.
// A stream byte or an unused mode gives one result, a voice restore gives
// two results (stream inactive), four or five (stream active), and a
// silence command two per unowned voice; a restore of voice 3 or a silence
// with every voice owned gives a single marker. The result sequencer emits
// one result per cycle through a registered output stage, so sustained rate
// is one result per clock while the output is ready; the parser runs ahead
// by up to QUEUE_DEPTH entries. The first result of an input passes through
// the queue and then the output register, and transfers when the output is ready.
module psg_register_frame_applier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  psgrfa_in_if.sink                            in_ch,
  psgrfa_out_if.source                         out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [psgrfa_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [psgrfa_pkg::CFG_DW-1:0]   cfg_wdata
);

  logic [7:0]        vol_gain_r;
  logic              stream_active_r;

  logic              push, pop, full, q_valid;
  psgrfa_pkg::ent_t  push_ent, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_gain_r      <= psgrfa_pkg::VOL_RESET;
      stream_active_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psgrfa_pkg::CFG_VOL_GAIN:      vol_gain_r      <= cfg_wdata[7:0];
        psgrfa_pkg::CFG_STREAM_ACTIVE: stream_active_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  psgrfa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .q_full        (full),
    .vol_gain      (vol_gain_r),
    .stream_active (stream_active_r),
    .push          (push),
    .push_ent      (push_ent)
  );

  psgrfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .head     (head)
  );

  psgrfa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .vol_gain (vol_gain_r),
    .q_pop    (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the register frame applier against a local model of the frame
// parser, the register shadow and the ownership and volume rules. A short
// directed table comes first, then random frames and commands under several
// volume and stream settings, with random idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]       MODE_UNUSED     = 2'd3;
  localparam int               ITEMS_PER_PHASE = 52;
  localparam int               NUM_PHASES      = 8;
  localparam int               CYCLE_LIMIT     = 200000;
  localparam int               DRAIN_CYCLES    = 20;
  localparam psgrfa_pkg::res_t NO_RES          = '0;

  typedef struct {
    logic [1:0]       mode;
    logic [7:0]       data;
    logic [1:0]       voice;
    logic [3:0]       own;
    bit               set_active;
    bit               typed;
    psgrfa_pkg::res_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                          cfg_we;
  logic [psgrfa_pkg::CFG_IW-1:0] cfg_index;
  logic [psgrfa_pkg::CFG_DW-1:0] cfg_wdata;
  logic                          sink_ready = 1'b0;

  psgrfa_in_if  in_ch ();
  psgrfa_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  psg_register_frame_applier u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // chip model state
  logic [7:0]         music_vol = psgrfa_pkg::VOL_RESET;
  logic               stream_on = 1'b0;
  psgrfa_pkg::phase_t frame_phase = psgrfa_pkg::PH_MASK_HI;
  logic [13:0]        frame_pending = '0;
  logic [7:0]         shadow_regs [14] = '{default: 8'd0};

  psgrfa_pkg::res_t step_results [$];
  psgrfa_pkg::res_t chip_writes_due [$];
  psgrfa_pkg::res_t due;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   phase_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  dir_row_t dir_rows [26];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic psgrfa_pkg::res_t idle_marker(logic fe);
    psgrfa_pkg::res_t x;
    x = NO_RES;
    x.kind = psgrfa_pkg::KIND_NONE;
    x.frame_end = fe;
    x.last = 1'b1;
    return x;
  endfunction

  function automatic void add_result(psgrfa_pkg::kind_t k, logic [3:0] r, logic [7:0] val,
                                     logic [5:0] mm, logic fe);
    psgrfa_pkg::res_t x;
    x.kind = k;
    x.reg_index = r;
    x.write_value = val;
    x.mixer_mask = mm;
    x.frame_end = fe;
    x.last = 1'b0;
    step_results.push_back(x);
  endfunction

  function automatic logic [7:0] scaled_volume(logic [7:0] val);
    logic [15:0] prod;
    prod = {8'd0, val} * {8'd0, music_vol};
    if (val[psgrfa_pkg::VOL_ENV_BIT]) return val;
    if (prod[15:7] > {1'b0, psgrfa_pkg::VOL_MAX}) return psgrfa_pkg::VOL_MAX;
    return prod[14:7];
  endfunction

  function automatic logic [5:0] voice_mix_bits(logic [1:0] v);
    return 6'(psgrfa_pkg::VOICE_MIX << v);
  endfunction

  function automatic logic effect_owns(logic [3:0] r, logic [3:0] own);
    if (r <= psgrfa_pkg::REG_TONE_HI) return own[r[2:1]];
    if (r >= psgrfa_pkg::REG_VOL_LO && r <= psgrfa_pkg::REG_VOL_HI)
      return own[r - psgrfa_pkg::REG_VOL_LO];
    if (r == psgrfa_pkg::REG_NOISE) return own[psgrfa_pkg::OWN_NOISE];
    return 1'b0;
  endfunction

  // fills step_results with the chip writes one input transfer causes
  function automatic void predict_chip_writes(logic [1:0] md, logic [7:0] b,
                                              logic [1:0] v, logic [3:0] own);
    logic [3:0] r;
    logic [5:0] keep;
    logic [5:0] vb;
    logic       fe;
    step_results.delete();
    if (md == psgrfa_pkg::MODE_STREAM) begin
      if (frame_phase == psgrfa_pkg::PH_MASK_LO) begin
        frame_pending = frame_pending | {6'd0, b};
        fe = (frame_pending == '0);
        frame_phase = fe ? psgrfa_pkg::PH_MASK_HI : psgrfa_pkg::PH_VALUES;
        add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, fe);
      end else if (frame_phase != psgrfa_pkg::PH_VALUES || frame_pending == '0) begin
        frame_pending = {b[5:0], 8'd0};
        frame_phase = psgrfa_pkg::PH_MASK_LO;
        add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, 1'b0);
      end else begin
        r = psgrfa_pkg::REG_LAST;
        for (int i = 12; i >= 0; i--) if (frame_pending[i]) r = 4'(i);
        shadow_regs[r] = b;
        frame_pending[r] = 1'b0;
        fe = (frame_pending == '0);
        if (fe) frame_phase = psgrfa_pkg::PH_MASK_HI;
        if (effect_owns(r, own)) begin
          add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, fe);
        end else if (r == psgrfa_pkg::REG_MIXER) begin
          keep = '0;
          for (int vc = 0; vc < 3; vc++) if (own[vc]) keep |= voice_mix_bits(2'(vc));
          add_result(psgrfa_pkg::KIND_MIXER, psgrfa_pkg::REG_MIXER,
                     {2'd0, b[5:0] & ~keep}, psgrfa_pkg::MIX_ALL & ~keep, fe);
        end else begin
          add_result(psgrfa_pkg::KIND_WRITE, r,
                     (r >= psgrfa_pkg::REG_VOL_LO && r <= psgrfa_pkg::REG_VOL_HI) ?
                     scaled_volume(b) : b,
                     6'd0, fe);
        end
      end
    end else if (md == psgrfa_pkg::MODE_RESTORE) begin
      if (v > 2'd2) begin
        add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, 1'b0);
      end else begin
        vb = voice_mix_bits(v);
        if (stream_on) begin
          add_result(psgrfa_pkg::KIND_WRITE, 4'({v, 1'b0}), shadow_regs[4'({v, 1'b0})],
                     6'd0, 1'b0);
          add_result(psgrfa_pkg::KIND_WRITE, 4'({v, 1'b1}), shadow_regs[4'({v, 1'b1})],
                     6'd0, 1'b0);
          add_result(psgrfa_pkg::KIND_WRITE, psgrfa_pkg::REG_VOL_LO + 4'(v),
                     scaled_volume(shadow_regs[psgrfa_pkg::REG_VOL_LO + 4'(v)]),
                     6'd0, 1'b0);
          if (!own[psgrfa_pkg::OWN_NOISE])
            add_result(psgrfa_pkg::KIND_WRITE, psgrfa_pkg::REG_NOISE,
                       shadow_regs[psgrfa_pkg::REG_NOISE], 6'd0, 1'b0);
          add_result(psgrfa_pkg::KIND_MIXER, psgrfa_pkg::REG_MIXER,
                     shadow_regs[psgrfa_pkg::REG_MIXER] & {2'd0, vb}, vb, 1'b0);
        end else begin
          add_result(psgrfa_pkg::KIND_WRITE, psgrfa_pkg::REG_VOL_LO + 4'(v), 8'd0,
                     6'd0, 1'b0);
          add_result(psgrfa_pkg::KIND_MIXER, psgrfa_pkg::REG_MIXER, {2'd0, vb}, vb, 1'b0);
        end
      end
    end else if (md == psgrfa_pkg::MODE_SILENCE) begin
      for (int vc = 0; vc < 3; vc++) begin
        if (!own[vc]) begin
          vb = voice_mix_bits(2'(vc));
          add_result(psgrfa_pkg::KIND_WRITE, psgrfa_pkg::REG_VOL_LO + 4'(vc), 8'd0,
                     6'd0, 1'b0);
          add_result(psgrfa_pkg::KIND_MIXER, psgrfa_pkg::REG_MIXER, {2'd0, vb}, vb, 1'b0);
        end
      end
      if (step_results.size() == 0)
        add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, 1'b0);
    end else begin
      add_result(psgrfa_pkg::KIND_NONE, 4'd0, 8'd0, 6'd0, 1'b0);
    end
    step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(input logic [1:0] md, input logic [7:0] b, input logic [1:0] v,
                           input logic [3:0] own, input bit typed = 1'b0,
                           input psgrfa_pkg::res_t want = NO_RES);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= md;
    in_ch.data_byte    <= b;
    in_ch.voice        <= v;
    in_ch.owned_voices <= own;
    do @(posedge clk); while (!in_ch.ready);
    predict_chip_writes(md, b, v, own);
    if (typed) chip_writes_due.push_back(want);
    else foreach (step_results[k]) chip_writes_due.push_back(step_results[k]);
    phase_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chip_writes_due.size() != 0);
  endtask

  task automatic set_config(input logic [7:0] vol, input logic act);
    cfg_we    <= 1'b1;
    cfg_index <= psgrfa_pkg::CFG_VOL_GAIN;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_index <= psgrfa_pkg::CFG_STREAM_ACTIVE;
    cfg_wdata <= {7'd0, act};
    @(posedge clk);
    cfg_we    <= 1'b0;
    music_vol = vol;
    stream_on = act;
  endtask

  task automatic send_command(input logic [3:0] own);
    send_item($urandom_range(1) ? psgrfa_pkg::MODE_RESTORE : psgrfa_pkg::MODE_SILENCE,
              8'($urandom), 2'($urandom), own);
  endtask

  // mostly whole frames with random content, the rest commands and stray bytes
  task automatic random_burst();
    int          pick;
    logic [13:0] mask14;
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(3))
        0:       mask14 = '0;
        1:       mask14 = 14'(1 << $urandom_range(13));
        2:       mask14 = 14'($urandom & $urandom);
        default: mask14 = 14'($urandom);
      endcase
      send_item(psgrfa_pkg::MODE_STREAM, {2'($urandom), mask14[13:8]}, 2'($urandom),
                4'($urandom));
      send_item(psgrfa_pkg::MODE_STREAM, mask14[7:0], 2'($urandom), 4'($urandom));
      for (int r = 0; r < 14; r++) begin
        if (mask14[r]) begin
          if ($urandom_range(99) < 8) send_command(4'($urandom));
          send_item(psgrfa_pkg::MODE_STREAM, 8'($urandom), 2'($urandom), 4'($urandom));
        end
      end
    end else if (pick < 82) begin
      send_item(psgrfa_pkg::MODE_RESTORE, 8'($urandom), 2'($urandom), 4'($urandom));
    end else if (pick < 92) begin
      send_item(psgrfa_pkg::MODE_SILENCE, 8'($urandom), 2'($urandom), 4'($urandom));
    end else if (pick < 95) begin
      send_item(MODE_UNUSED, 8'($urandom), 2'($urandom), 4'($urandom));
    end else begin
      send_item(psgrfa_pkg::MODE_STREAM, 8'($urandom), 2'($urandom), 4'($urandom));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_ch.valid && sink_ready) begin
      if (chip_writes_due.size() == 0) begin
        $error("unexpected transfer: kind %0d reg %0d value %0h", out_ch.kind,
               out_ch.reg_index, out_ch.write_value);
        fail_count++;
      end else begin
        due = chip_writes_due.pop_front();
        if (out_ch.kind !== due.kind) begin
          $error("kind: expected %0d, got %0d", due.kind, out_ch.kind);
          fail_count++;
        end
        if (out_ch.reg_index !== due.reg_index) begin
          $error("reg_index: expected %0d, got %0d", due.reg_index, out_ch.reg_index);
          fail_count++;
        end
        if (out_ch.write_value !== due.write_value) begin
          $error("write_value: expected %0h, got %0h", due.write_value, out_ch.write_value);
          fail_count++;
        end
        if (out_ch.mixer_mask !== due.mixer_mask) begin
          $error("mixer_mask: expected %0h, got %0h", due.mixer_mask, out_ch.mixer_mask);
          fail_count++;
        end
        if (out_ch.frame_end !== due.frame_end) begin
          $error("frame_end: expected %0b, got %0b", due.frame_end, out_ch.frame_end);
          fail_count++;
        end
        if (out_ch.last !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, out_ch.last);
          fail_count++;
        end
      end
    end
    sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] vol_pick;
    in_ch.valid        = 1'b0;
    in_ch.mode         = psgrfa_pkg::MODE_STREAM;
    in_ch.data_byte    = 8'd0;
    in_ch.voice        = 2'd0;
    in_ch.owned_voices = 4'd0;
    cfg_we             = 1'b0;
    cfg_index          = psgrfa_pkg::CFG_VOL_GAIN;
    cfg_wdata          = '0;

    dir_rows = '{
      '{MODE_UNUSED,              8'hA5, 2'd2, 4'hF, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_RESTORE, 8'h00, 2'd3, 4'h0, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_SILENCE, 8'hFF, 2'd0, 4'h7, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_RESTORE, 8'h00, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_SILENCE, 8'h00, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hFF, 2'd0, 4'h0, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_STREAM,  8'hFF, 2'd0, 4'h0, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_RESTORE, 8'h00, 2'd1, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h00, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hFF, 2'd0, 4'h1, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h12, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h34, 2'd0, 4'hE, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h56, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h0F, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h1F, 2'd0, 4'h8, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hFF, 2'd0, 4'h5, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h1F, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hEF, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h07, 2'd0, 4'h4, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hAB, 2'd0, 4'hF, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hCD, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'hEF, 2'd0, 4'h0, 1'b0, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_STREAM,  8'h00, 2'd0, 4'h0, 1'b0, 1'b1, idle_marker(1'b0)},
      '{psgrfa_pkg::MODE_STREAM,  8'h00, 2'd0, 4'h0, 1'b0, 1'b1, idle_marker(1'b1)},
      '{psgrfa_pkg::MODE_RESTORE, 8'h00, 2'd2, 4'h0, 1'b1, 1'b0, NO_RES},
      '{psgrfa_pkg::MODE_RESTORE, 8'h00, 2'd0, 4'h8, 1'b0, 1'b0, NO_RES}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_active) begin
        wait_idle();
        set_config(music_vol, 1'b1);
      end
      send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].voice, dir_rows[i].own,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0, 2, 7: vol_pick = psgrfa_pkg::VOL_RESET;
        1:       vol_pick = 8'd0;
        3:       vol_pick = 8'd1;
        default: vol_pick = 8'($urandom_range(128));
      endcase
      set_config(vol_pick, (p != 2 && p != 4));
      send_idle_pct  = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 10 : 0;
      recv_stall_pct = (p % 4 == 2) ? 53 : (p % 4 == 3) ? 10 : 0;
      phase_sent = 0;
      while (phase_sent < ITEMS_PER_PHASE) random_burst();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/psgrfa_pkg.sv
rtl/psgrfa_in_if.sv
rtl/psgrfa_out_if.sv
rtl/psgrfa_front.sv
rtl/psgrfa_queue.sv
rtl/psgrfa_back.sv
rtl/psg_register_frame_applier.sv
dv/testbench.sv
